// ===== design/rc_frame_receiver_crc8_unpack_core_assert.svh =====
// Assertion macros shared by the RC frame receiver RTL.
`ifndef RC_FRAME_RECEIVER_CRC8_UNPACK_CORE_ASSERT_SVH
`define RC_FRAME_RECEIVER_CRC8_UNPACK_CORE_ASSERT_SVH

// same-cycle implication
`define RFCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfcu assertion failed");

// next-cycle implication
`define RFCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfcu assertion failed");

`endif

// ===== design/rfcu_pkg.sv =====
// Types and constants of the RC frame receiver.
package rfcu_pkg;

  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned CH_BITS       = 11;
  localparam int unsigned CHANNELS      = 16;
  localparam int unsigned STORE_BITS    = PAYLOAD_BYTES * 8;

  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [7:0]  RC_LENGTH    = 8'd24;
  localparam logic [7:0]  DEV_ADDR_RST = 8'd200;
  localparam logic [7:0]  RC_TYPE_RST  = 8'd22;
  localparam logic [15:0] FAILSAFE_RST = 16'd500;

  typedef enum logic [1:0] {
    REG_DEV_ADDR = 2'd0,
    REG_RC_TYPE  = 2'd1,
    REG_FAILSAFE = 2'd2
  } reg_idx_e;

  typedef enum logic [0:0] {
    KIND_CHANNEL = 1'b0,
    KIND_STATUS  = 1'b1
  } result_kind_e;

  typedef enum logic [0:0] {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CRC  = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_TICK = 4'b1000
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } store_ctrl_t;

endpackage

// ===== design/rfcu_crc8.sv =====
// Bit-serial CRC-8 (poly 0xD5, MSB first): one shift per cycle, eight per byte.
module rfcu_crc8 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfcu_pkg::crc_ctrl_t ctrl_i,
  output logic [7:0]         crc_o,
  output logic               busy_o
);

  logic [7:0] crc_q, crc_d;
  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      crc_d = '0;
    end else if (ctrl_i.start) begin
      crc_d  = crc_q ^ ctrl_i.data;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (crc_q[7]) begin
        crc_d = {crc_q[6:0], 1'b0} ^ rfcu_pkg::CRC_POLY;
      end else begin
        crc_d = {crc_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = busy_q;

endmodule

// ===== design/rfcu_payload.sv =====
// Payload shift store: bytes shift in at the top, channels shift out 11 bits at a time.
module rfcu_payload (
  input  logic                        clk_i,
  input  rfcu_pkg::store_ctrl_t       ctrl_i,
  output logic [rfcu_pkg::CH_BITS-1:0] channel_o
);

  logic [rfcu_pkg::STORE_BITS-1:0] store_q, store_d;

  always_comb begin
    store_d = store_q;
    if (ctrl_i.push) begin
      // after 22 pushes, payload byte 0 sits at the bottom
      store_d = {ctrl_i.data, store_q[rfcu_pkg::STORE_BITS-1:8]};
    end else if (ctrl_i.pop) begin
      store_d = store_q >> rfcu_pkg::CH_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  assign channel_o = store_q[rfcu_pkg::CH_BITS-1:0];

endmodule

// ===== design/rc_frame_receiver_crc8_unpack_core.sv =====
// Top level of the RC frame receiver: frame parser, tick counter, output register, APB.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  input    | in        | in_valid_i/in_stall_o | action_i, rx_byte_i
//  result   | out       | out_valid_o/out_stall_i | result_kind_o .. last_o
//  config   | in        | psel/penable/pwrite  | paddr, pwdata, prdata
//
// A payload or type byte holds the input while the serial CRC runs eight shifts; sync,
// length and bad CRC bytes do not stall it, and a tick holds it until its status is registered.
// A good RC frame then emits 16 channel transfers, one per cycle the output register is free.
// Reset clears the parser, counter, CRC and output valid; the payload store holds no reset.
// A stalled result holds the output register; the next input is still taken while the parser is idle.
`include "rc_frame_receiver_crc8_unpack_core_assert.svh"

module rc_frame_receiver_crc8_unpack_core #(
  parameter int unsigned MAX_FRAME_BYTES = 64,
  parameter int unsigned TICK_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic        link_up_o,
  output logic        last_o
);

  localparam int unsigned CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [TICK_BITS-1:0] TICK_TOP = {TICK_BITS{1'b1}};

  // configuration registers
  logic [7:0]  dev_addr_q, rc_type_q;
  logic [15:0] failsafe_q;
  logic        cfg_wr;
  rfcu_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = rfcu_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= rfcu_pkg::DEV_ADDR_RST;
      rc_type_q  <= rfcu_pkg::RC_TYPE_RST;
      failsafe_q <= rfcu_pkg::FAILSAFE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rfcu_pkg::REG_DEV_ADDR: dev_addr_q <= pwdata[7:0];
        rfcu_pkg::REG_RC_TYPE:  rc_type_q  <= pwdata[7:0];
        rfcu_pkg::REG_FAILSAFE: failsafe_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rfcu_pkg::REG_DEV_ADDR: prdata = {24'd0, dev_addr_q};
      rfcu_pkg::REG_RC_TYPE:  prdata = {24'd0, rc_type_q};
      rfcu_pkg::REG_FAILSAFE: prdata = {16'd0, failsafe_q};
      default:                prdata = '0;
    endcase
  end

  // parser state
  rfcu_pkg::state_e state_q, state_d;
  logic [6:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [3:0]  ch_q, ch_d;
  logic [TICK_BITS-1:0] ticks_q, ticks_d;

  // output register
  logic        ov_q, ov_d;
  logic        okind_q, okind_d;
  logic [3:0]  oidx_q, oidx_d;
  logic [10:0] oval_q, oval_d;
  logic        oup_q, oup_d;
  logic        olast_q, olast_d;

  rfcu_pkg::crc_ctrl_t   crc_ctrl;
  rfcu_pkg::store_ctrl_t st_ctrl;
  logic [7:0]  crc_val;
  logic        crc_busy;
  logic [10:0] chan_val;

  rfcu_crc8 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_val),
    .busy_o (crc_busy)
  );

  rfcu_payload u_payload (
    .clk_i     (clk_i),
    .ctrl_i    (st_ctrl),
    .channel_o (chan_val)
  );

  logic       in_fire, slot_free, len_bad, in_body, is_store, good;
  logic [6:0] k;
  logic [7:0] body;
  logic       link_now;

  assign in_stall_o = (state_q != rfcu_pkg::ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign slot_free  = ~ov_q | ~out_stall_i;

  assign k        = pos_q - 7'd2;
  assign body     = len_q - 8'd1;
  assign in_body  = ({1'b0, k} < body);
  assign is_store = (k != 7'd0) && (k <= 7'(rfcu_pkg::PAYLOAD_BYTES));
  assign len_bad  = (rx_byte_i < 8'd2) ||
                    ((9'(rx_byte_i) + 9'd2) > 9'(MAX_FRAME_BYTES));
  assign good     = (crc_val == rx_byte_i) && (type_q == rc_type_q) &&
                    (len_q == rfcu_pkg::RC_LENGTH);
  assign link_now = (CMP_W'(ticks_q) < CMP_W'(failsafe_q));

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    len_d    = len_q;
    type_d   = type_q;
    ch_d     = ch_q;
    ticks_d  = ticks_q;
    crc_ctrl = '0;
    st_ctrl  = '0;
    crc_ctrl.data = rx_byte_i;
    st_ctrl.data  = rx_byte_i;

    ov_d    = ov_q & out_stall_i;
    okind_d = okind_q;
    oidx_d  = oidx_q;
    oval_d  = oval_q;
    oup_d   = oup_q;
    olast_d = olast_q;

    case (state_q)
      rfcu_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (action_i == rfcu_pkg::ACT_TICK) begin
            if (ticks_q != TICK_TOP) begin
              ticks_d = ticks_q + 1'b1;
            end
            state_d = rfcu_pkg::ST_TICK;
          end else if (pos_q == 7'd0) begin
            if (rx_byte_i == dev_addr_q) begin
              pos_d = 7'd1;
            end
          end else if (pos_q == 7'd1) begin
            len_d = rx_byte_i;
            if (len_bad) begin
              pos_d = 7'd0;
            end else begin
              crc_ctrl.clear = 1'b1;
              pos_d          = 7'd2;
            end
          end else if (in_body) begin
            crc_ctrl.start = 1'b1;
            if (k == 7'd0) begin
              type_d = rx_byte_i;
            end
            st_ctrl.push = is_store;
            pos_d        = pos_q + 7'd1;
            state_d      = rfcu_pkg::ST_CRC;
          end else begin
            // CRC byte closes the frame
            pos_d = 7'd0;
            if (good) begin
              ticks_d = '0;
              ch_d    = '0;
              state_d = rfcu_pkg::ST_EMIT;
            end
          end
        end
      end
      rfcu_pkg::ST_CRC: begin
        if (!crc_busy && !crc_ctrl.start) begin
          state_d = rfcu_pkg::ST_IDLE;
        end
      end
      rfcu_pkg::ST_EMIT: begin
        if (slot_free) begin
          ov_d        = 1'b1;
          okind_d     = rfcu_pkg::KIND_CHANNEL;
          oidx_d      = ch_q;
          oval_d      = chan_val;
          oup_d       = 1'b0;
          olast_d     = (ch_q == 4'(rfcu_pkg::CHANNELS - 1));
          st_ctrl.pop = 1'b1;
          ch_d        = ch_q + 4'd1;
          if (ch_q == 4'(rfcu_pkg::CHANNELS - 1)) begin
            state_d = rfcu_pkg::ST_IDLE;
          end
        end
      end
      rfcu_pkg::ST_TICK: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          okind_d = rfcu_pkg::KIND_STATUS;
          oidx_d  = '0;
          oval_d  = '0;
          oup_d   = link_now;
          olast_d = 1'b1;
          state_d = rfcu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rfcu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfcu_pkg::ST_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      ch_q    <= '0;
      ticks_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
      ch_q    <= ch_d;
      ticks_q <= ticks_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    oup_q   <= oup_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = okind_q;
  assign channel_index_o = oidx_q;
  assign channel_value_o = oval_q;
  assign link_up_o       = oup_q;
  assign last_o          = olast_q;

  `RFCU_ASSERT_IMP(a_crc_busy_in_crc, clk_i, rst_ni, crc_busy, state_q == rfcu_pkg::ST_CRC)
  `RFCU_ASSERT_NXT(a_tick_to_status, clk_i, rst_ni,
    in_fire && action_i == rfcu_pkg::ACT_TICK, state_q == rfcu_pkg::ST_TICK)
  `RFCU_ASSERT_IMP(a_last_channel, clk_i, rst_ni,
    ov_q && olast_q && okind_q == rfcu_pkg::KIND_CHANNEL, oidx_q == 4'd15)

endmodule

// ===== tb/sv/rc_frame_receiver_crc8_unpack_core_test.sv =====
// Self-checking testbench for the RC frame receiver: framed byte and tick traffic, APB setup.
module rc_frame_receiver_crc8_unpack_core_test;

  localparam int unsigned MAX_FRAME    = 64;
  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned SHOW_MAX     = 60;

  typedef struct packed {
    rfcu_pkg::result_kind_e kind;
    logic [3:0]             idx;
    logic [10:0]            value;
    logic                   up;
    logic                   last;
  } rc_result_t;

  typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_e;

  class rc_frame_scoreboard;
    logic [7:0]  dev_addr;
    logic [7:0]  rc_type;
    logic [15:0] failsafe;
    int unsigned pos;
    logic [7:0]  flen;
    logic [7:0]  crc;
    logic [7:0]  ftype;
    logic [7:0]  payload [rfcu_pkg::PAYLOAD_BYTES];
    logic [15:0] ticks;
    rc_result_t  pending_results [$];
    int unsigned errors;
    int unsigned shown;

    function new();
      dev_addr = rfcu_pkg::DEV_ADDR_RST;
      rc_type  = rfcu_pkg::RC_TYPE_RST;
      failsafe = rfcu_pkg::FAILSAFE_RST;
      pos      = 0;
      flen     = '0;
      crc      = '0;
      ftype    = '0;
      ticks    = '0;
      errors   = 0;
      shown    = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void write_reg(rfcu_pkg::reg_idx_e r, logic [31:0] v);
      case (r)
        rfcu_pkg::REG_DEV_ADDR: dev_addr = v[7:0];
        rfcu_pkg::REG_RC_TYPE:  rc_type  = v[7:0];
        rfcu_pkg::REG_FAILSAFE: failsafe = v[15:0];
        default: ;
      endcase
    endfunction

    // MSB-first, no reflection, init 0
    function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
      c = c ^ b;
      for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ rfcu_pkg::CRC_POLY) : (c << 1);
      return c;
    endfunction

    function logic [10:0] unpack_channel(int unsigned ch);
      logic [rfcu_pkg::STORE_BITS-1:0] flat;
      for (int i = 0; i < rfcu_pkg::PAYLOAD_BYTES; i++) flat[i*8 +: 8] = payload[i];
      return flat[ch*rfcu_pkg::CH_BITS +: rfcu_pkg::CH_BITS];
    endfunction

    function void note_input(rfcu_pkg::action_e act, logic [7:0] b);
      int unsigned k;
      rc_result_t r;
      if (act == rfcu_pkg::ACT_TICK) begin
        if (ticks != '1) ticks++;
        r = '{kind: rfcu_pkg::KIND_STATUS, idx: 4'd0, value: 11'd0, up: (ticks < failsafe),
              last: 1'b1};
        pending_results.push_back(r);
        return;
      end
      case (pos)
        0: if (b == dev_addr) pos = 1;
        1: begin
          flen = b;
          if (b < 2 || int'(b) + 2 > MAX_FRAME) begin
            pos = 0;
          end else begin
            crc = '0;
            pos = 2;
          end
        end
        default: begin
          k = pos - 2;
          if (k < int'(flen) - 1) begin
            crc = crc8_next(crc, b);
            if (k == 0) ftype = b;
            else if (k - 1 < rfcu_pkg::PAYLOAD_BYTES) payload[k-1] = b;
            pos++;
          end else begin
            pos = 0;
            if (crc == b && ftype == rc_type && flen == rfcu_pkg::RC_LENGTH) begin
              for (int ch = 0; ch < rfcu_pkg::CHANNELS; ch++) begin
                r = '{kind: rfcu_pkg::KIND_CHANNEL, idx: 4'(ch), value: unpack_channel(ch),
                      up: 1'b0, last: (ch == rfcu_pkg::CHANNELS - 1)};
                pending_results.push_back(r);
              end
              ticks = '0;
            end
          end
        end
      endcase
    endfunction

    function void report(string what, int unsigned want_v, int unsigned got_v);
      errors++;
      if (shown < SHOW_MAX)
        $display("%0t %s: expected %0d, got %0d", $time, what, want_v, got_v);
      shown++;
    endfunction

    function void check_result(rc_result_t got);
      rc_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (shown < SHOW_MAX)
          $display({"%0t unexpected transfer: expected none, ",
                    "got kind %0d idx %0d value %0d up %0d last %0d"},
                   $time, got.kind, got.idx, got.value, got.up, got.last);
        shown++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)   report("result_kind", want.kind, got.kind);
      if (got.idx !== want.idx)     report("channel_index", want.idx, got.idx);
      if (got.value !== want.value) report("channel_value", want.value, got.value);
      if (got.up !== want.up)       report("link_up", want.up, got.up);
      if (got.last !== want.last)   report("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        action_i    = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic        link_up_o;
  logic        last_o;

  rc_frame_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned counted_items  = 0;
  int unsigned cycle_count    = 0;

  rc_frame_receiver_crc8_unpack_core u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    rc_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind: rfcu_pkg::result_kind_e'(result_kind_o), idx: channel_index_o,
              value: channel_value_o, up: link_up_o, last: last_o};
      sb.check_result(got);
    end
  end

  task automatic send_item(rfcu_pkg::action_e act, logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, b);
    counted_items++;
  endtask

  // ticks land inside frames now and then; they must not disturb the parser
  task automatic frame_byte(logic [7:0] b);
    if ($urandom_range(99) < 4) send_item(rfcu_pkg::ACT_TICK, 8'($urandom));
    send_item(rfcu_pkg::ACT_BYTE, b);
  endtask

  task automatic send_frame(logic [7:0] len, logic [7:0] ftype, fill_e fill, bit bad_crc);
    logic [7:0] c;
    logic [7:0] b;
    send_item(rfcu_pkg::ACT_BYTE, sb.dev_addr);
    frame_byte(len);
    if (len < 2 || int'(len) + 2 > MAX_FRAME) return;
    c = sb.crc8_next(8'h00, ftype);
    frame_byte(ftype);
    for (int i = 0; i < int'(len) - 2; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      c = sb.crc8_next(c, b);
      frame_byte(b);
    end
    if (bad_crc) c = c ^ 8'($urandom_range(255, 1));
    frame_byte(c);
  endtask

  task automatic send_noise(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == sb.dev_addr) b = ~b;
      send_item(rfcu_pkg::ACT_BYTE, b);
    end
    counted_items -= n;
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned start;
    int unsigned r;
    logic [7:0]  len;
    start = counted_items;
    while (counted_items - start < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_frame(rfcu_pkg::RC_LENGTH, sb.rc_type, FILL_RANDOM, 1'b0);
      end else if (r < 47) begin
        repeat ($urandom_range(8, 1)) send_item(rfcu_pkg::ACT_TICK, 8'($urandom));
      end else if (r < 55) begin
        send_frame(rfcu_pkg::RC_LENGTH, sb.rc_type, FILL_RANDOM, 1'b1);
      end else if (r < 62) begin
        send_frame(8'($urandom_range(MAX_FRAME - 2, 2)), 8'($urandom), FILL_RANDOM, 1'b0);
      end else if (r < 68) begin
        len = 8'($urandom_range(MAX_FRAME - 2, 2));
        if (len == rfcu_pkg::RC_LENGTH) len = rfcu_pkg::RC_LENGTH + 1;
        send_frame(len, sb.rc_type, FILL_RANDOM, 1'b0);
      end else if (r < 74) begin
        len = ($urandom_range(1)) ? 8'($urandom_range(1))
                                  : 8'($urandom_range(255, MAX_FRAME - 1));
        send_frame(len, sb.rc_type, FILL_RANDOM, 1'b0);
      end else if (r < 86) begin
        send_noise($urandom_range(4, 1));
      end else begin
        // cut-off frame: the following traffic is swallowed as its body
        send_item(rfcu_pkg::ACT_BYTE, sb.dev_addr);
        send_item(rfcu_pkg::ACT_BYTE, rfcu_pkg::RC_LENGTH);
        repeat ($urandom_range(10, 1)) send_item(rfcu_pkg::ACT_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic apb_xfer(bit wr, rfcu_pkg::reg_idx_e r, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reg(rfcu_pkg::reg_idx_e r, logic [31:0] v);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (r == rfcu_pkg::REG_FAILSAFE) ? 32'h0000_FFFF : 32'h0000_00FF;
    apb_xfer(1'b1, r, v, rd);
    sb.write_reg(r, v);
    apb_xfer(1'b0, r, 32'd0, rd);
    if ((rd & mask) !== (v & mask)) sb.report("register readback", v & mask, rd & mask);
  endtask

  // drop valid, let every expected transfer arrive, then let a byte in flight finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_phase(logic [7:0] addr, logic [7:0] rtype, logic [15:0] fs,
                           int unsigned idle_pct, int unsigned stall_pct);
    settle();
    set_reg(rfcu_pkg::REG_DEV_ADDR, addr);
    set_reg(rfcu_pkg::REG_RC_TYPE, rtype);
    set_reg(rfcu_pkg::REG_FAILSAFE, fs);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_phase(rfcu_pkg::DEV_ADDR_RST, rfcu_pkg::RC_TYPE_RST, rfcu_pkg::FAILSAFE_RST, 0, 0);
    // directed: tick byte ignored, noise, dropped lengths, full-scale and zero channels
    send_item(rfcu_pkg::ACT_TICK, 8'h00);
    send_item(rfcu_pkg::ACT_TICK, 8'hFF);
    send_item(rfcu_pkg::ACT_BYTE, 8'h00);
    send_item(rfcu_pkg::ACT_BYTE, 8'hFF);
    send_frame(8'd0, rfcu_pkg::RC_TYPE_RST, FILL_RANDOM, 1'b0);
    send_frame(8'd1, rfcu_pkg::RC_TYPE_RST, FILL_RANDOM, 1'b0);
    send_frame(8'(MAX_FRAME - 1), rfcu_pkg::RC_TYPE_RST, FILL_RANDOM, 1'b0);
    send_frame(8'd2, 8'h7F, FILL_RANDOM, 1'b0);
    send_frame(rfcu_pkg::RC_LENGTH, rfcu_pkg::RC_TYPE_RST, FILL_ONES, 1'b0);
    send_frame(rfcu_pkg::RC_LENGTH, rfcu_pkg::RC_TYPE_RST, FILL_ZERO, 1'b0);
    random_traffic(25);

    set_phase(8'h00, 8'hFF, 16'd1, 52, 0);
    random_traffic(25);

    set_phase(8'hFF, 8'h00, 16'hFFFF, 0, 52);
    random_traffic(25);

    set_phase(8'($urandom), 8'($urandom), 16'($urandom_range(40, 2)), 27, 27);
    random_traffic(25);

    // zero timeout: link never reported up, even right after a good frame
    set_phase(8'($urandom), 8'($urandom), 16'd0, 0, 0);
    repeat (3) send_item(rfcu_pkg::ACT_TICK, 8'($urandom));
    send_frame(rfcu_pkg::RC_LENGTH, sb.rc_type, FILL_RANDOM, 1'b0);
    repeat (3) send_item(rfcu_pkg::ACT_TICK, 8'($urandom));
    settle();

    sb.errors += sb.pending_results.size();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
